[design/immediate_load_pair_patcher_top_macros.svh]
// Assertion macros shared by the patcher checker.
`ifndef IMMEDIATE_LOAD_PAIR_PATCHER_TOP_MACROS_SVH
`define IMMEDIATE_LOAD_PAIR_PATCHER_TOP_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ILPP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define ILPP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[design/ilpp_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ilpp_pkg
// Constants, register codes and shared types for the load pair patcher.
// ----------------------------------------------------------------------------
package ilpp_pkg;

  localparam logic [31:0] UPPER_OPCODE     = 32'h1400_0000;
  localparam logic [31:0] UPPER_MATCH_MASK = 32'hffff_ffe0;
  localparam logic [31:0] OR_OPCODE        = 32'h0380_0000;
  localparam logic [31:0] UPPER_KEEP_MASK  = 32'hfe00_001f;
  localparam logic [31:0] OR_KEEP_MASK     = 32'hffc0_03ff;

  localparam int unsigned REG_BITS  = 5;
  localparam int unsigned CFG_IDX_BITS = 2;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_OLD_HASH    = 2'd0,
    REG_NEW_HASH    = 2'd1,
    REG_REPORT_ONLY = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [31:0] old_hash;
    logic [31:0] new_hash;
    logic        report_only;
  } cfg_t;

endpackage
`default_nettype wire

[design/ilpp_scan.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ilpp_scan
// Input register, match logic and held upper-load state; emits a record pair.
// ----------------------------------------------------------------------------
module ilpp_scan #(
  parameter int POSITION_BITS = 20,
  localparam int REC_W = POSITION_BITS + 34
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  input  wire logic [31:0]              in_word,
  input  wire logic [POSITION_BITS-1:0] in_pos,
  input  wire logic                     in_start,
  input  wire ilpp_pkg::cfg_t           cfg,
  output logic                          pair_valid,
  output logic [REC_W-1:0]              upper_rec,
  output logic [REC_W-1:0]              or_rec
);
  import ilpp_pkg::*;

  logic                     iv;
  logic [31:0]              iw;
  logic [POSITION_BITS-1:0] ip;
  logic                     is_start;

  logic                     armed;
  logic [REG_BITS-1:0]      held_reg;
  logic [31:0]              held_word;
  logic [POSITION_BITS-1:0] held_pos;

  logic        armed_eff;
  logic        upper_hit;
  logic        or_hit;
  logic        clobber;
  logic [31:0] upper_key;
  logic [31:0] or_key;
  logic [31:0] upper_patched;
  logic [31:0] or_patched;

  always_ff @(posedge clk) begin
    if (rst) begin
      iv <= 1'b0;
    end else begin
      iv <= in_valid;
    end
    iw       <= in_word;
    ip       <= in_pos;
    is_start <= in_start;
  end

  always_comb begin
    armed_eff     = armed & ~is_start;
    upper_key     = UPPER_OPCODE | {7'b0, cfg.old_hash[31:12], 5'b0};
    or_key        = OR_OPCODE | {10'b0, cfg.old_hash[11:0], held_reg, held_reg};
    upper_hit     = (iw & UPPER_MATCH_MASK) == upper_key;
    or_hit        = iw == or_key;
    clobber       = iw[REG_BITS-1:0] == held_reg;
    upper_patched = (held_word & UPPER_KEEP_MASK) | {7'b0, cfg.new_hash[31:12], 5'b0};
    or_patched    = (iw & OR_KEEP_MASK) | {10'b0, cfg.new_hash[11:0], 10'b0};
    pair_valid    = iv & armed_eff & or_hit;
    upper_rec     = {1'b0, cfg.report_only, upper_patched, held_pos};
    or_rec        = {1'b1, cfg.report_only, or_patched, ip};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      armed     <= 1'b0;
      held_reg  <= '0;
      held_word <= '0;
      held_pos  <= '0;
    end else if (iv) begin
      if (!armed_eff) begin
        armed <= upper_hit;
        if (upper_hit) begin
          held_reg  <= iw[REG_BITS-1:0];
          held_word <= iw;
          held_pos  <= ip;
        end
      end else if (or_hit || clobber) begin
        armed <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

[design/ilpp_outq.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ilpp_outq
// Record queue: takes a pair of records at once, releases one word a cycle while out_ready is high.
// ----------------------------------------------------------------------------
module ilpp_outq #(
  parameter int POSITION_BITS = 20,
  localparam int REC_W = POSITION_BITS + 34
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [REC_W-1:0] push_a,
  input  wire logic [REC_W-1:0] push_b,
  output logic                  space_ok,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [REC_W-1:0]      out_rec
);
  localparam int DEPTH  = 8;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int CNT_W  = PTR_W + 1;

  logic [REC_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic [CNT_W-1:0] count_next;
  logic             pop;

  always_comb begin
    pop        = out_valid & out_ready;
    count_next = count + (push ? CNT_W'(2) : CNT_W'(0)) - (pop ? CNT_W'(1) : CNT_W'(0));
    out_valid  = count != '0;
    out_rec    = mem[rd_ptr];
    // room for one pair in flight plus one pair from the next word
    space_ok   = count <= CNT_W'(DEPTH - 4);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr]            <= push_a;
      mem[wr_ptr + PTR_W'(1)] <= push_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(2);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count_next;
    end
  end

endmodule
`default_nettype wire

[design/immediate_load_pair_patcher_top.sv]
// An accepted word is registered in the scan input stage; a matched pair is pushed into
// the record queue. Throughput: one word per cycle while tready is high; a match gives
// two output words, one per cycle while m_axis_tready is high, drained from an
// eight-entry record queue; tready drops while it holds more than four. Reset (rst,
// synchronous): clears the held upper load, the queue and the configuration registers.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// immediate_load_pair_patcher_top
// Finds an upper-load / OR-immediate pair loading the old hash, patches both.
// ----------------------------------------------------------------------------
module immediate_load_pair_patcher_top #(
  parameter int POSITION_BITS = 20,
  localparam int DATA_W = ((32 + POSITION_BITS + 7) / 8) * 8
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [DATA_W-1:0]              s_axis_tdata,  // instruction, word_position
  input  wire logic                           s_axis_tuser,  // block_start
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [DATA_W-1:0]                   m_axis_tdata,  // patch_position, patched_word
  output logic                                m_axis_tuser,  // flag_only
  output logic                                m_axis_tlast,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [ilpp_pkg::CFG_IDX_BITS-1:0] cfg_index,
  input  wire logic [31:0]                    cfg_data
);
  import ilpp_pkg::*;

  localparam int REC_W = POSITION_BITS + 34;

  cfg_t             cfg;
  logic             in_acc;
  logic             pair_valid;
  logic [REC_W-1:0] upper_rec;
  logic [REC_W-1:0] or_rec;
  logic [REC_W-1:0] out_rec;
  logic             space_ok;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = space_ok;
  assign in_acc        = s_axis_tvalid & s_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_OLD_HASH:    cfg.old_hash    <= cfg_data;
        REG_NEW_HASH:    cfg.new_hash    <= cfg_data;
        REG_REPORT_ONLY: cfg.report_only <= cfg_data[0];
        default: ;
      endcase
    end
  end

  ilpp_scan #(.POSITION_BITS(POSITION_BITS)) u_scan (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_acc),
    .in_word    (s_axis_tdata[31:0]),
    .in_pos     (s_axis_tdata[32 +: POSITION_BITS]),
    .in_start   (s_axis_tuser),
    .cfg        (cfg),
    .pair_valid (pair_valid),
    .upper_rec  (upper_rec),
    .or_rec     (or_rec)
  );

  ilpp_outq #(.POSITION_BITS(POSITION_BITS)) u_outq (
    .clk       (clk),
    .rst       (rst),
    .push      (pair_valid),
    .push_a    (upper_rec),
    .push_b    (or_rec),
    .space_ok  (space_ok),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_rec   (out_rec)
  );

  assign m_axis_tdata = DATA_W'(out_rec[POSITION_BITS+31:0]);
  assign m_axis_tuser = out_rec[POSITION_BITS+32];
  assign m_axis_tlast = out_rec[POSITION_BITS+33];

endmodule
`default_nettype wire

[design/ilpp_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
`include "immediate_load_pair_patcher_top_macros.svh"
// ----------------------------------------------------------------------------
// ilpp_checker
// Port-level checks on the patcher output stream, bound to the top level.
// ----------------------------------------------------------------------------
module ilpp_checker #(
  parameter int POSITION_BITS = 20,
  localparam int DATA_W = ((32 + POSITION_BITS + 7) / 8) * 8
) (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              m_axis_tvalid,
  input wire logic                              m_axis_tready,
  input wire logic [DATA_W-1:0]                 m_axis_tdata,
  input wire logic                              m_axis_tuser,
  input wire logic                              m_axis_tlast
);

  `ILPP_ASSERT_NEXT(a_pair_follows, clk, rst, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tvalid && m_axis_tlast, "upper-load word not followed by its OR word")

  `ILPP_ASSERT_NEXT(a_pair_flag, clk, rst, m_axis_tvalid && m_axis_tready && !m_axis_tlast, m_axis_tuser == $past(m_axis_tuser), "flag differs within a pair")

  `ILPP_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled output word changed")

  `ILPP_ASSERT_NOW(a_reset_empty, clk, rst, $past(rst), !m_axis_tvalid, "output valid straight after reset")

endmodule

bind immediate_load_pair_patcher_top ilpp_checker #(.POSITION_BITS(POSITION_BITS)) u_chk (.*);
`default_nettype wire
